[rtl/core/touch_pressure_pointer_mapper_unit_defines.svh]
// assertion macros for the touch pressure pointer mapper
// used by the top level only; no other dependencies
`ifndef TOUCH_PRESSURE_POINTER_MAPPER_UNIT_DEFINES_SVH
`define TOUCH_PRESSURE_POINTER_MAPPER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TPPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TPPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TPPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/tppm_pkg.sv]
// shared types and constants for the touch pressure pointer mapper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tppm_pkg;

  localparam int AXIS_W    = 16;
  localparam int SPAN_W    = 14;
  localparam int PROD_W    = AXIS_W + SPAN_W;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] CMD_SYNC = 2'd0;
  localparam logic [1:0] CMD_ABS  = 2'd1;

  localparam logic [AXIS_W-1:0] AXIS_X        = 16'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y        = 16'd1;
  localparam logic [AXIS_W-1:0] AXIS_PRESSURE = 16'd24;

  localparam logic [1:0] BTN_NONE    = 2'd0;
  localparam logic [1:0] BTN_PRESS   = 2'd1;
  localparam logic [1:0] BTN_RELEASE = 2'd2;

  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_FILL_X = 2'd1;
  localparam logic [1:0] MODE_FILL_Y = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_X_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Y_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd7;

  typedef struct packed {
    logic [1:0]        scale_mode;
    logic [AXIS_W-1:0] press_level;
    logic [AXIS_W-1:0] lift_level;
    logic [AXIS_W-1:0] move_level;
    logic [AXIS_W-1:0] sensor_x_max;
    logic [AXIS_W-1:0] sensor_y_max;
    logic [SPAN_W-1:0] window_width;
    logic [SPAN_W-1:0] window_height;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    scale_mode:    MODE_FILL_X,
    press_level:   16'd50,
    lift_level:    16'd20,
    move_level:    16'd0,
    sensor_x_max:  16'd4095,
    sensor_y_max:  16'd4095,
    window_width:  14'd1920,
    window_height: 14'd1080
  };

  typedef struct packed {
    logic              start;
    logic [AXIS_W-1:0] pos;
    logic [SPAN_W-1:0] span;
    logic [AXIS_W-1:0] maxv;
  } scale_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [AXIS_W-1:0] value;
  } scale_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_START,
    ST_X_WAIT,
    ST_Y_START,
    ST_Y_WAIT,
    ST_LOAD
  } ctrl_state_t;

endpackage

`default_nettype wire

[rtl/core/tppm_if.sv]
// valid/ready channel interfaces for requests, results and register writes
// depends on tppm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tppm_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [tppm_pkg::AXIS_W-1:0]   axis_code;
  logic [tppm_pkg::AXIS_W-1:0]   axis_value;
  modport source (output valid, cmd, axis_code, axis_value, input ready);
  modport sink (input valid, cmd, axis_code, axis_value, output ready);
endinterface

interface tppm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          move_valid;
  logic [tppm_pkg::AXIS_W-1:0]   pointer_x;
  logic [tppm_pkg::AXIS_W-1:0]   pointer_y;
  logic [1:0]                    button_action;
  modport source (output valid, move_valid, pointer_x, pointer_y, button_action, input ready);
  modport sink (input valid, move_valid, pointer_x, pointer_y, button_action, output ready);
endinterface

interface tppm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tppm_pkg::CFG_IDX_W-1:0] index;
  logic [tppm_pkg::AXIS_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/tppm_cfg_regs.sv]
// configuration register file, written through the register write channel
// depends on tppm_pkg and tppm_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module tppm_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  tppm_cfg_if.sink            cfg_bus,
  output tppm_pkg::cfg_regs_t cfg
);
  import tppm_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_SCALE_MODE:    cfg_nxt.scale_mode    = cfg_bus.data[1:0];
        REG_PRESS_LEVEL:   cfg_nxt.press_level   = cfg_bus.data;
        REG_LIFT_LEVEL:    cfg_nxt.lift_level    = cfg_bus.data;
        REG_MOVE_LEVEL:    cfg_nxt.move_level    = cfg_bus.data;
        REG_SENSOR_X_MAX:  cfg_nxt.sensor_x_max  = cfg_bus.data;
        REG_SENSOR_Y_MAX:  cfg_nxt.sensor_y_max  = cfg_bus.data;
        REG_WINDOW_WIDTH:  cfg_nxt.window_width  = cfg_bus.data[SPAN_W-1:0];
        REG_WINDOW_HEIGHT: cfg_nxt.window_height = cfg_bus.data[SPAN_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tppm_scale_unit.sv]
// shared scaling unit: one multiply, then a restoring divide one bit a cycle
// depends on tppm_pkg
`timescale 1ns / 1ps
`default_nettype none

module tppm_scale_unit #(
  parameter logic [15:0] COORD_LIMIT = 16'hFFFF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tppm_pkg::scale_req_t req,
  output tppm_pkg::scale_rsp_t rsp
);
  import tppm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0] dvd_r, dvd_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [AXIS_W-1:0] rem_r, rem_nxt;
  logic [AXIS_W-1:0] maxv_r, maxv_nxt;
  logic [AXIS_W-1:0] value_r, value_nxt;
  logic [AXIS_W:0]   rem_sh;
  logic              q_bit;

  assign rem_sh = {rem_r, dvd_r[PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, maxv_r});

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    maxv_nxt  = maxv_r;
    value_nxt = value_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(PROD_W - 1);
      dvd_nxt  = PROD_W'(req.pos) * PROD_W'(req.span);
      quo_nxt  = '0;
      rem_nxt  = '0;
      maxv_nxt = req.maxv;
    end else if (busy_r) begin
      rem_nxt = q_bit ? AXIS_W'(rem_sh - {1'b0, maxv_r}) : rem_sh[AXIS_W-1:0];
      dvd_nxt = {dvd_r[PROD_W-2:0], 1'b0};
      quo_nxt = {quo_r[PROD_W-2:0], q_bit};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        // divide by zero gives all ones and lands on the limit
        value_nxt = (quo_nxt > PROD_W'(COORD_LIMIT)) ? COORD_LIMIT : quo_nxt[AXIS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    maxv_r  <= maxv_nxt;
    value_r <= value_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule

`default_nettype wire

[rtl/core/touch_pressure_pointer_mapper_unit.sv]
// a sync with move runs two 30-step divides on the shared unit, X then Y, before the
// result register; a sync without move skips the divides; absolute and other events give no result
// throughput: one absolute or other event per cycle while idle; a sync holds off new requests
// until its result is loaded, the single bit-serial divider being used for X then Y;
// a stalled result holds the block in its load state
// reset: synchronous active low, registers to defaults, held X, Y, pressure to zero
`timescale 1ns / 1ps
`default_nettype none
`include "touch_pressure_pointer_mapper_unit_defines.svh"

module touch_pressure_pointer_mapper_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tppm_in_if.sink    in_bus,
  tppm_out_if.source out_bus,
  tppm_cfg_if.sink   cfg_bus
);
  import tppm_pkg::*;

  localparam logic [63:0] LIMIT_WIDE = (64'd1 << COORD_BITS) - 64'd1;
  localparam logic [AXIS_W-1:0] COORD_LIMIT =
    (COORD_BITS >= AXIS_W) ? {AXIS_W{1'b1}} : LIMIT_WIDE[AXIS_W-1:0];

  cfg_regs_t   cfg;
  scale_req_t  scale_req;
  scale_rsp_t  scale_rsp;

  ctrl_state_t       state_r, state_nxt;
  logic [AXIS_W-1:0] held_x_r, held_x_nxt;
  logic [AXIS_W-1:0] held_y_r, held_y_nxt;
  logic [AXIS_W-1:0] held_p_r, held_p_nxt;
  logic [AXIS_W-1:0] op_x_r, op_x_nxt;
  logic [AXIS_W-1:0] op_y_r, op_y_nxt;
  logic              mv_r, mv_nxt;
  logic [1:0]        btn_r, btn_nxt;
  logic [AXIS_W-1:0] px_r, px_nxt;
  logic [AXIS_W-1:0] py_r, py_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_mv_r, out_mv_nxt;
  logic [AXIS_W-1:0] out_px_r, out_px_nxt;
  logic [AXIS_W-1:0] out_py_r, out_py_nxt;
  logic [1:0]        out_btn_r, out_btn_nxt;
  logic              in_take;
  logic [SPAN_W-1:0] span_x, span_y;
  logic [AXIS_W-1:0] maxv_x, maxv_y;

  tppm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  tppm_scale_unit #(
    .COORD_LIMIT (COORD_LIMIT)
  ) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scale_req),
    .rsp   (scale_rsp)
  );

  // operand selection per mode
  always_comb begin
    case (cfg.scale_mode)
      MODE_FULL: begin
        span_x = cfg.window_width;  maxv_x = cfg.sensor_x_max;
        span_y = cfg.window_height; maxv_y = cfg.sensor_y_max;
      end
      MODE_FILL_X: begin
        span_x = cfg.window_width;  maxv_x = cfg.sensor_x_max;
        span_y = cfg.window_width;  maxv_y = cfg.sensor_x_max;
      end
      MODE_FILL_Y: begin
        span_x = cfg.window_height; maxv_x = cfg.sensor_y_max;
        span_y = cfg.window_height; maxv_y = cfg.sensor_y_max;
      end
      default: begin
        span_x = SPAN_W'(1);        maxv_x = AXIS_W'(1);
        span_y = SPAN_W'(1);        maxv_y = AXIS_W'(1);
      end
    endcase
  end

  always_comb begin
    scale_req.start = (state_r == ST_X_START) || (state_r == ST_Y_START);
    scale_req.pos   = (state_r == ST_Y_START) ? op_y_r : op_x_r;
    scale_req.span  = (state_r == ST_Y_START) ? span_y : span_x;
    scale_req.maxv  = (state_r == ST_Y_START) ? maxv_y : maxv_x;
  end

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_take      = in_bus.valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    held_x_nxt    = held_x_r;
    held_y_nxt    = held_y_r;
    held_p_nxt    = held_p_r;
    op_x_nxt      = op_x_r;
    op_y_nxt      = op_y_r;
    mv_nxt        = mv_r;
    btn_nxt       = btn_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_mv_nxt    = out_mv_r;
    out_px_nxt    = out_px_r;
    out_py_nxt    = out_py_r;
    out_btn_nxt   = out_btn_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take && ((in_bus.cmd == CMD_SYNC) || (in_bus.cmd == CMD_ABS))) begin
          if (in_bus.cmd == CMD_SYNC) begin
            op_x_nxt = held_x_r;
            op_y_nxt = held_y_r;
            mv_nxt   = (held_p_r >= cfg.move_level);
            px_nxt   = '0;
            py_nxt   = '0;
            if (held_p_r >= cfg.press_level) begin
              btn_nxt = BTN_PRESS;
            end else if (held_p_r <= cfg.lift_level) begin
              btn_nxt = BTN_RELEASE;
            end else begin
              btn_nxt = BTN_NONE;
            end
            state_nxt = (held_p_r >= cfg.move_level) ? ST_X_START : ST_LOAD;
          end
          // a zero X is a spurious jump
          if ((in_bus.axis_code == AXIS_X) && (in_bus.axis_value != '0)) begin
            held_x_nxt = in_bus.axis_value;
          end else if (in_bus.axis_code == AXIS_Y) begin
            held_y_nxt = in_bus.axis_value;
          end else if (in_bus.axis_code == AXIS_PRESSURE) begin
            held_p_nxt = in_bus.axis_value;
          end
        end
      end
      ST_X_START: state_nxt = ST_X_WAIT;
      ST_X_WAIT: begin
        if (scale_rsp.done) begin
          px_nxt    = scale_rsp.value;
          state_nxt = ST_Y_START;
        end
      end
      ST_Y_START: state_nxt = ST_Y_WAIT;
      ST_Y_WAIT: begin
        if (scale_rsp.done) begin
          py_nxt    = scale_rsp.value;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_mv_nxt    = mv_r;
          out_px_nxt    = px_r;
          out_py_nxt    = py_r;
          out_btn_nxt   = btn_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_p_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
      held_p_r    <= held_p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_x_r    <= op_x_nxt;
    op_y_r    <= op_y_nxt;
    mv_r      <= mv_nxt;
    btn_r     <= btn_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    out_mv_r  <= out_mv_nxt;
    out_px_r  <= out_px_nxt;
    out_py_r  <= out_py_nxt;
    out_btn_r <= out_btn_nxt;
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.move_valid    = out_mv_r;
  assign out_bus.pointer_x     = out_px_r;
  assign out_bus.pointer_y     = out_py_r;
  assign out_bus.button_action = out_btn_r;

  `TPPM_ASSERT_SAME(a_busy_blocks_input, clk, rst_n, scale_rsp.busy, !in_bus.ready, "request taken while scaling")
  `TPPM_ASSERT_SAME(a_no_move_zero, clk, rst_n, out_bus.valid && !out_bus.move_valid, (out_bus.pointer_x == '0) && (out_bus.pointer_y == '0), "pointer set without move")
  `TPPM_ASSERT_SAME(a_btn_code, clk, rst_n, out_bus.valid, (out_bus.button_action == BTN_NONE) || (out_bus.button_action == BTN_PRESS) || (out_bus.button_action == BTN_RELEASE), "bad button code")
  `TPPM_ASSERT_NEXT(a_x_then_y, clk, rst_n, scale_rsp.done && (state_r == ST_X_WAIT), state_r == ST_Y_START, "y scaling not started after x")

endmodule

`default_nettype wire

[test/touch_pressure_pointer_mapper_unit_tb.sv]
// self-checking testbench for the touch pressure pointer mapper unit
// depends on tppm_pkg, tppm_if and the unit itself; drives touch events and register
// writes, predicts each sync report and checks every output field against it
`timescale 1ns / 1ps

module touch_pressure_pointer_mapper_unit_tb;
  import tppm_pkg::*;

  localparam int COORD_BITS = 16;
  localparam logic [31:0] COORD_MAX =
    (COORD_BITS >= 16) ? 32'h0000_FFFF : ((32'd1 << COORD_BITS) - 32'd1);
  localparam logic [1:0] CMD_OTHER = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;
  localparam int ITEMS_PER_SETTING = 115;
  localparam int RANDOM_SETTINGS   = 6;
  localparam int DRAIN_CYCLES      = 100;
  localparam int STALL_LIMIT       = 3000;

  typedef struct packed {
    logic              move_valid;
    logic [AXIS_W-1:0] pointer_x;
    logic [AXIS_W-1:0] pointer_y;
    logic [1:0]        button_action;
  } report_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [AXIS_W-1:0] code;
    logic [AXIS_W-1:0] value;
    logic              typed;
    report_t           want;
  } stim_row_t;

  localparam report_t NO_WANT = '0;
  localparam report_t IDLE_RELEASE = '{1'b1, 16'd0, 16'd0, BTN_RELEASE};

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_SYNC,  16'hFFFF,      16'h0000, 1'b1, IDLE_RELEASE},
    '{CMD_ABS,   AXIS_X,        16'h0000, 1'b0, NO_WANT},
    '{CMD_SYNC,  16'h0002,      16'hFFFF, 1'b1, IDLE_RELEASE},
    '{CMD_ABS,   AXIS_X,        16'hFFFF, 1'b0, NO_WANT},
    '{CMD_ABS,   AXIS_Y,        16'hFFFF, 1'b0, NO_WANT},
    '{CMD_ABS,   AXIS_PRESSURE, 16'hFFFF, 1'b0, NO_WANT},
    '{CMD_SYNC,  16'h0003,      16'h0000, 1'b0, NO_WANT},
    '{CMD_ABS,   AXIS_X,        16'h0000, 1'b0, NO_WANT},
    '{CMD_SYNC,  16'h0004,      16'h1111, 1'b0, NO_WANT},
    '{CMD_ABS,   AXIS_PRESSURE, 16'd50,   1'b0, NO_WANT},
    '{CMD_SYNC,  16'h0005,      16'h0000, 1'b0, NO_WANT},
    '{CMD_ABS,   AXIS_PRESSURE, 16'd49,   1'b0, NO_WANT},
    '{CMD_SYNC,  16'h0006,      16'h0000, 1'b0, NO_WANT},
    '{CMD_ABS,   AXIS_PRESSURE, 16'd20,   1'b0, NO_WANT},
    '{CMD_SYNC,  16'h0007,      16'h0000, 1'b0, NO_WANT},
    '{CMD_OTHER, AXIS_X,        16'h1234, 1'b0, NO_WANT},
    '{CMD_RSVD,  AXIS_PRESSURE, 16'hFFFF, 1'b0, NO_WANT},
    '{CMD_ABS,   16'hFFFF,      16'h5555, 1'b0, NO_WANT},
    '{CMD_ABS,   16'd25,        16'h0000, 1'b0, NO_WANT},
    '{CMD_SYNC,  AXIS_PRESSURE, 16'd21,   1'b0, NO_WANT},
    '{CMD_SYNC,  AXIS_X,        16'h0001, 1'b0, NO_WANT},
    '{CMD_SYNC,  AXIS_Y,        16'h0000, 1'b0, NO_WANT},
    '{CMD_SYNC,  AXIS_X,        16'hAAAA, 1'b0, NO_WANT},
    '{CMD_SYNC,  16'h0000,      16'h0000, 1'b0, NO_WANT}
  };

  localparam int N_FIXED = 7;
  localparam cfg_regs_t FIXED_SETTINGS [N_FIXED] = '{
    '{MODE_FULL,   16'd50,    16'd20,    16'd0,     16'd4095,  16'd4095,  14'd1920, 14'd1080},
    '{MODE_FILL_Y, 16'd1000,  16'd500,   16'd200,   16'd1023,  16'd767,   14'd800,  14'd600},
    '{MODE_NONE,   16'hFFFF,  16'd0,     16'hFFFF,  16'hFFFF,  16'hFFFF,  14'd8192, 14'd8192},
    '{MODE_FULL,   16'd0,     16'hFFFF,  16'd0,     16'd1,     16'd1,     14'd8192, 14'd8192},
    '{MODE_FILL_X, 16'd10,    16'd100,   16'd0,     16'd0,     16'd0,     14'd1,    14'd1},
    '{MODE_FULL,   16'd300,   16'd100,   16'd50,    16'd4095,  16'd4095,  14'd0,    14'd0},
    '{MODE_FILL_Y, 16'd40000, 16'd30000, 16'd10000, 16'd100,   16'd0,     14'd16383, 14'd16383}
  };

  logic clk;
  logic rst_n;

  tppm_in_if  in_bus ();
  tppm_out_if out_bus ();
  tppm_cfg_if cfg_bus ();

  touch_pressure_pointer_mapper_unit #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  cfg_regs_t         shadow_cfg;
  logic [AXIS_W-1:0] track_x;
  logic [AXIS_W-1:0] track_y;
  logic [AXIS_W-1:0] track_pressure;
  report_t           pending_reports [$];
  report_t           seen_report;
  report_t           want_report;

  int err_count;
  int n_requests;
  int n_reports;
  int n_writes;
  int n_settings;
  int stall_count;
  int burst_left;
  logic [15:0] rx_tick;
  logic [1:0]  rx_style;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [AXIS_W-1:0] scaled_coord(logic [AXIS_W-1:0] pos,
                                                     logic [SPAN_W-1:0] span,
                                                     logic [AXIS_W-1:0] maxv);
    logic [63:0] prod;
    logic [63:0] quot;
    if (maxv == '0) return COORD_MAX[AXIS_W-1:0];
    prod = 64'(pos) * 64'(span);
    quot = prod / 64'(maxv);
    if (quot > 64'(COORD_MAX)) return COORD_MAX[AXIS_W-1:0];
    return quot[AXIS_W-1:0];
  endfunction

  function automatic report_t sync_report();
    report_t r;
    r = '0;
    if (track_pressure >= shadow_cfg.move_level) begin
      r.move_valid = 1'b1;
      case (shadow_cfg.scale_mode)
        MODE_FULL: begin
          r.pointer_x = scaled_coord(track_x, shadow_cfg.window_width, shadow_cfg.sensor_x_max);
          r.pointer_y = scaled_coord(track_y, shadow_cfg.window_height, shadow_cfg.sensor_y_max);
        end
        MODE_FILL_X: begin
          r.pointer_x = scaled_coord(track_x, shadow_cfg.window_width, shadow_cfg.sensor_x_max);
          r.pointer_y = scaled_coord(track_y, shadow_cfg.window_width, shadow_cfg.sensor_x_max);
        end
        MODE_FILL_Y: begin
          r.pointer_x = scaled_coord(track_x, shadow_cfg.window_height, shadow_cfg.sensor_y_max);
          r.pointer_y = scaled_coord(track_y, shadow_cfg.window_height, shadow_cfg.sensor_y_max);
        end
        default: begin
          r.pointer_x = (32'(track_x) > COORD_MAX) ? COORD_MAX[AXIS_W-1:0] : track_x;
          r.pointer_y = (32'(track_y) > COORD_MAX) ? COORD_MAX[AXIS_W-1:0] : track_y;
        end
      endcase
    end
    if (track_pressure >= shadow_cfg.press_level) r.button_action = BTN_PRESS;
    else if (track_pressure <= shadow_cfg.lift_level) r.button_action = BTN_RELEASE;
    else r.button_action = BTN_NONE;
    return r;
  endfunction

  task automatic apply_axis(logic [AXIS_W-1:0] code, logic [AXIS_W-1:0] value);
    // zero x is a spurious jump and keeps the old value
    if (code == AXIS_X) begin
      if (value != '0) track_x = value;
    end else if (code == AXIS_Y) begin
      track_y = value;
    end else if (code == AXIS_PRESSURE) begin
      track_pressure = value;
    end
  endtask

  task automatic record_request(logic [1:0] cmd, logic [AXIS_W-1:0] code,
                                logic [AXIS_W-1:0] value, logic typed, report_t want);
    report_t r;
    if (cmd == CMD_ABS) begin
      apply_axis(code, value);
    end else if (cmd == CMD_SYNC) begin
      r = sync_report();
      pending_reports.push_back(typed ? want : r);
      apply_axis(code, value);
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(negedge clk) in_bus.valid <= 1'b0;
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_request(logic [1:0] cmd, logic [AXIS_W-1:0] code,
                              logic [AXIS_W-1:0] value, logic typed, report_t want);
    @(negedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= cmd;
    in_bus.axis_code  <= code;
    in_bus.axis_value <= value;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    record_request(cmd, code, value, typed, want);
    n_requests++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AXIS_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_SCALE_MODE:    shadow_cfg.scale_mode    = data[1:0];
      REG_PRESS_LEVEL:   shadow_cfg.press_level   = data;
      REG_LIFT_LEVEL:    shadow_cfg.lift_level    = data;
      REG_MOVE_LEVEL:    shadow_cfg.move_level    = data;
      REG_SENSOR_X_MAX:  shadow_cfg.sensor_x_max  = data;
      REG_SENSOR_Y_MAX:  shadow_cfg.sensor_y_max  = data;
      REG_WINDOW_WIDTH:  shadow_cfg.window_width  = data[SPAN_W-1:0];
      REG_WINDOW_HEIGHT: shadow_cfg.window_height = data[SPAN_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk) cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk) in_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(cfg_regs_t c);
    drain();
    write_reg(REG_SCALE_MODE,    {14'd0, c.scale_mode});
    write_reg(REG_PRESS_LEVEL,   c.press_level);
    write_reg(REG_LIFT_LEVEL,    c.lift_level);
    write_reg(REG_MOVE_LEVEL,    c.move_level);
    write_reg(REG_SENSOR_X_MAX,  c.sensor_x_max);
    write_reg(REG_SENSOR_Y_MAX,  c.sensor_y_max);
    write_reg(REG_WINDOW_WIDTH,  {2'd0, c.window_width});
    write_reg(REG_WINDOW_HEIGHT, {2'd0, c.window_height});
    n_settings++;
  endtask

  function automatic cfg_regs_t random_settings();
    cfg_regs_t c;
    c.scale_mode    = 2'($urandom_range(0, 3));
    c.press_level   = 16'($urandom);
    c.lift_level    = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, c.press_level))
                                                  : 16'($urandom);
    c.move_level    = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    c.sensor_x_max  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 64))
                                                  : 16'($urandom_range(1, 65535));
    c.sensor_y_max  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 64))
                                                  : 16'($urandom_range(1, 65535));
    c.window_width  = 14'($urandom_range(1, 8192));
    c.window_height = 14'($urandom_range(1, 8192));
    return c;
  endfunction

  function automatic logic [AXIS_W-1:0] pick_code();
    case ($urandom_range(0, 7))
      0, 1:    return AXIS_X;
      2, 3:    return AXIS_Y;
      4, 5:    return AXIS_PRESSURE;
      6:       return 16'($urandom_range(2, 30));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] pick_pos(logic [AXIS_W-1:0] maxv);
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return maxv;
      3, 4:    return 16'($urandom);
      default: return 16'($urandom_range(0, maxv));
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] pick_pressure();
    case ($urandom_range(0, 11))
      0:       return shadow_cfg.press_level;
      1:       return shadow_cfg.press_level - 16'd1;
      2:       return shadow_cfg.lift_level;
      3:       return shadow_cfg.lift_level + 16'd1;
      4:       return shadow_cfg.move_level;
      5:       return shadow_cfg.move_level - 16'd1;
      6:       return 16'h0000;
      7:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_traffic(int count);
    int sent;
    logic [1:0] cmd;
    logic [AXIS_W-1:0] code;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        // one well-formed report: axis updates then a sync
        if ($urandom_range(0, 3) != 0) begin
          pace();
          send_request(CMD_ABS, AXIS_X, pick_pos(shadow_cfg.sensor_x_max), 1'b0, NO_WANT);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          pace();
          send_request(CMD_ABS, AXIS_Y, pick_pos(shadow_cfg.sensor_y_max), 1'b0, NO_WANT);
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          pace();
          send_request(CMD_ABS, AXIS_PRESSURE, pick_pressure(), 1'b0, NO_WANT);
          sent++;
        end
        pace();
        code = pick_code();
        send_request(CMD_SYNC, code,
                     (code == AXIS_PRESSURE) ? pick_pressure() : 16'($urandom), 1'b0, NO_WANT);
        sent++;
      end else begin
        cmd  = 2'($urandom_range(0, 3));
        code = pick_code();
        pace();
        send_request(cmd, code, 16'($urandom), 1'b0, NO_WANT);
        if (cmd == CMD_SYNC || cmd == CMD_ABS) sent++;
      end
    end
  endtask

  // receiver back-pressure, changing style whenever the low byte of rx_tick wraps to zero
  always @(negedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    if (rx_tick[7:0] == 8'd0) rx_style <= 2'($urandom_range(0, 3));
    case (rx_style)
      2'd0:    out_bus.ready <= 1'b1;
      2'd1:    out_bus.ready <= ($urandom_range(0, 99) < 60);
      2'd2:    out_bus.ready <= (rx_tick[1:0] == 2'd0);
      default: out_bus.ready <= (rx_tick[5:4] != 2'd0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      seen_report = '{out_bus.move_valid, out_bus.pointer_x, out_bus.pointer_y,
                      out_bus.button_action};
      n_reports++;
      if (pending_reports.size() == 0) begin
        $error("unexpected report: move_valid=%0b x=%0d y=%0d button=%0d",
               seen_report.move_valid, seen_report.pointer_x, seen_report.pointer_y,
               seen_report.button_action);
        err_count++;
      end else begin
        want_report = pending_reports.pop_front();
        if (seen_report.move_valid !== want_report.move_valid) begin
          $error("move_valid: expected %0b, got %0b", want_report.move_valid,
                 seen_report.move_valid);
          err_count++;
        end
        if (seen_report.pointer_x !== want_report.pointer_x) begin
          $error("pointer_x: expected %0d, got %0d", want_report.pointer_x,
                 seen_report.pointer_x);
          err_count++;
        end
        if (seen_report.pointer_y !== want_report.pointer_y) begin
          $error("pointer_y: expected %0d, got %0d", want_report.pointer_y,
                 seen_report.pointer_y);
          err_count++;
        end
        if (seen_report.button_action !== want_report.button_action) begin
          $error("button_action: expected %0d, got %0d", want_report.button_action,
                 seen_report.button_action);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted request, report or write
  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d reports outstanding", stall_count,
               pending_reports.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.cmd         = CMD_SYNC;
    in_bus.axis_code   = '0;
    in_bus.axis_value  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_SCALE_MODE;
    cfg_bus.data       = '0;
    out_bus.ready      = 1'b0;
    rx_tick            = '0;
    rx_style           = 2'd0;
    err_count          = 0;
    n_requests         = 0;
    n_reports          = 0;
    n_writes           = 0;
    n_settings         = 1;
    stall_count        = 0;
    burst_left         = 0;
    shadow_cfg         = CFG_RESET;
    track_x            = '0;
    track_y            = '0;
    track_pressure     = '0;

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      pace();
      send_request(DIRECTED[i].cmd, DIRECTED[i].code, DIRECTED[i].value, DIRECTED[i].typed,
                   DIRECTED[i].want);
    end
    random_traffic(ITEMS_PER_SETTING);

    for (int p = 0; p < N_FIXED; p++) begin
      load_settings(FIXED_SETTINGS[p]);
      random_traffic(ITEMS_PER_SETTING);
    end
    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      load_settings(random_settings());
      random_traffic(ITEMS_PER_SETTING);
    end

    drain();
    $display("%0d requests and %0d reports checked across %0d register settings",
             n_requests, n_reports, n_settings);
    $display("%0d register writes, all scale modes, threshold edges and saturation cases",
             n_writes);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
